>>> src/fpra_pkg.sv
// Shared types, constants and helper functions for the fixed-point to radix ASCII converter.
package fpra_pkg;

    // Default geometry of the fixed-point input
    localparam int unsigned INT_BITS_DEF      = 31;
    localparam int unsigned FRAC_BITS_DEF     = 32;
    localparam int unsigned MAX_FRAC_DIG_DEF  = 32;

    // Stream and configuration port widths
    localparam int unsigned S_DATA_W   = 64;   // value_q (63 bits) padded to whole bytes
    localparam int unsigned M_DATA_W   = 8;    // text_char (7 bits) padded to a byte
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned RADIX_W    = 5;
    localparam int unsigned FDIG_W     = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;

    // Bits of the integer part handled per divider cycle
    localparam int unsigned DIV_CHUNK  = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = 2'd1;

    // Register reset values and radix limits
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A    = 7'h41;
    localparam logic [CHAR_W-1:0] CH_DOT  = 7'h2E;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INT_RD,
        ST_INT_PUT,
        ST_DOT,
        ST_FRAC
    } t_state;

    // Digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dz;
        dz = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_LIMIT) begin
            digit_char = CH_ZERO + dz;
        end else begin
            digit_char = CH_A + dz - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_LIMIT};
        end
    endfunction

endpackage

>>> src/fpra_arith.sv
// Shared arithmetic unit: one 8-bit chunk of division by the radix, and fraction times radix.
module fpra_arith #(
    parameter int unsigned FRAC_BITS = fpra_pkg::FRAC_BITS_DEF
) (
    input  logic [fpra_pkg::RADIX_W-1:0]   i_base,
    // division chunk
    input  logic [fpra_pkg::DIGIT_W-1:0]   i_rem,
    input  logic [fpra_pkg::DIV_CHUNK-1:0] i_chunk,
    output logic [fpra_pkg::DIV_CHUNK-1:0] o_qbits,
    output logic [fpra_pkg::DIGIT_W-1:0]   o_rem,
    // fraction multiply
    input  logic [FRAC_BITS-1:0]           i_frac,
    output logic [fpra_pkg::DIGIT_W-1:0]   o_fdigit,
    output logic [FRAC_BITS-1:0]           o_frac
);
    import fpra_pkg::*;

    logic [RADIX_W-1:0]           part;
    logic [FRAC_BITS+RADIX_W-1:0] prod;

    // Restoring division, one quotient bit per step, remainder stays below the base
    always_comb begin
        part = {1'b0, i_rem};
        for (int k = DIV_CHUNK - 1; k >= 0; k--) begin
            part = {part[RADIX_W-2:0], i_chunk[k]};
            if (part >= i_base) begin
                part       = part - i_base;
                o_qbits[k] = 1'b1;
            end else begin
                o_qbits[k] = 1'b0;
            end
        end
        o_rem = part[DIGIT_W-1:0];
    end

    // Next fraction digit is the integer part of fraction * base
    always_comb begin
        prod     = {{RADIX_W{1'b0}}, i_frac} * {{FRAC_BITS{1'b0}}, i_base};
        o_fdigit = prod[FRAC_BITS +: DIGIT_W];
        o_frac   = prod[FRAC_BITS-1:0];
    end

endmodule

>>> src/fpra_digit_mem.sv
// Integer digit store, least significant digit at address zero, registered read.
module fpra_digit_mem #(
    parameter int unsigned DEPTH = fpra_pkg::INT_BITS_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [fpra_pkg::DIGIT_W-1:0]  i_wr_data,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [fpra_pkg::DIGIT_W-1:0]  o_rd_data
);
    import fpra_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

>>> src/fixed_point_to_radix_ascii.sv
// Top level: converts one unsigned fixed-point value into a stream of ASCII characters.
//
// Input stream (i_s_*): one item per value; tdata[62:0] holds the fixed-point
// value, INT_BITS integer bits above FRAC_BITS fraction bits. Output stream
// (o_m_*): one item per character, tdata[6:0] the ASCII code, tlast on the
// final character. Configuration (i_cfg_*): index 0 = radix (low 5 data bits,
// 2..16, values outside saturate), index 1 = number of fraction digits (saturates at
// MAX_FRAC_DIGITS); write only while the block is idle.
// Timing: the integer part is divided by the radix in an 8-bit-per-cycle
// shared divider, one 8-bit chunk after another for each integer digit.
// Each integer digit is then emitted from a read state and a put state, as
// the digit store read is registered; the '.' comes from the dot state and
// each fraction digit from the fraction state (one fraction*radix multiply
// each). One value is converted at a time and o_s_tready is high only when idle.
// Reset clears the sequencer and the output valid and restores radix 10 and
// zero fraction digits. A stalled receiver holds the output register and the
// sequencer waits; a new value may be accepted while the last character waits.
module fixed_point_to_radix_ascii #(
    parameter int unsigned INT_BITS        = fpra_pkg::INT_BITS_DEF,
    parameter int unsigned FRAC_BITS       = fpra_pkg::FRAC_BITS_DEF,
    parameter int unsigned MAX_FRAC_DIGITS = fpra_pkg::MAX_FRAC_DIG_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [fpra_pkg::S_DATA_W-1:0]     i_s_tdata,   // [62:0] value_q, [63] zero
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [fpra_pkg::M_DATA_W-1:0]     o_m_tdata,   // [6:0] text_char, [7] zero
    output logic                              o_m_tlast,   // is_last
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fpra_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpra_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fpra_pkg::*;

    localparam int unsigned DIV_CYC = (INT_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int unsigned DW      = DIV_CYC * DIV_CHUNK;
    localparam int unsigned AW      = $clog2(INT_BITS);
    localparam int unsigned CYC_W   = $clog2(DIV_CYC + 1);
    localparam logic [AW-1:0]     IDX_LAST = AW'(INT_BITS - 1);
    localparam logic [CYC_W-1:0]  CYC_LAST = CYC_W'(DIV_CYC - 1);
    localparam logic [FDIG_W-1:0] FDIG_MAX = FDIG_W'(MAX_FRAC_DIGITS);

    t_state               r_state, n_state;
    logic [RADIX_W-1:0]   r_cfg_radix;
    logic [FDIG_W-1:0]    r_cfg_frac;
    logic [RADIX_W-1:0]   r_base, n_base;
    logic [FDIG_W-1:0]    r_nfrac, n_nfrac;
    logic [DW-1:0]        r_dvd, n_dvd;
    logic [DIGIT_W-1:0]   r_rem, n_rem;
    logic [CYC_W-1:0]     r_cyc, n_cyc;
    logic [AW-1:0]        r_idx, n_idx;
    logic [FRAC_BITS-1:0] r_frac, n_frac;
    logic [FDIG_W-1:0]    r_fcnt, n_fcnt;
    logic                 r_m_valid, n_m_valid;
    logic [CHAR_W-1:0]    r_m_char, n_m_char;
    logic                 r_m_last, n_m_last;

    logic                 s_acc;
    logic                 out_free;
    logic [DW+DIV_CHUNK-1:0] dvd_sh;
    logic [DIV_CHUNK-1:0] qbits;
    logic [DIGIT_W-1:0]   rem_out;
    logic [DIGIT_W-1:0]   fdigit;
    logic [FRAC_BITS-1:0] frac_out;
    logic                 mem_wr;
    logic [DIGIT_W-1:0]   mem_rd_data;
    logic [RADIX_W-1:0]   radix_sat;
    logic [FDIG_W-1:0]    frac_sat;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_valid || i_m_tready;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = {1'b0, r_m_char};
    assign o_m_tlast   = r_m_last;

    // Saturated configuration values, latched per item
    assign radix_sat = (r_cfg_radix < RADIX_MIN) ? RADIX_MIN :
                       (r_cfg_radix > RADIX_MAX) ? RADIX_MAX : r_cfg_radix;
    assign frac_sat  = (r_cfg_frac > FDIG_MAX) ? FDIG_MAX : r_cfg_frac;

    fpra_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .i_base   (r_base),
        .i_rem    (r_rem),
        .i_chunk  (r_dvd[DW-1 -: DIV_CHUNK]),
        .o_qbits  (qbits),
        .o_rem    (rem_out),
        .i_frac   (r_frac),
        .o_fdigit (fdigit),
        .o_frac   (frac_out)
    );

    assign dvd_sh = {r_dvd, qbits};
    assign mem_wr = (r_state == ST_DIV) && (r_cyc == CYC_LAST);

    fpra_digit_mem #(
        .DEPTH (INT_BITS),
        .AW    (AW)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_idx),
        .i_wr_data (rem_out),
        .i_rd_addr (r_idx),
        .o_rd_data (mem_rd_data)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_radix <= RADIX_RESET;
            r_cfg_frac  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIX:       r_cfg_radix <= i_cfg_data[RADIX_W-1:0];
                REG_FRAC_DIGITS: r_cfg_frac  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_base    <= RADIX_RESET;
            r_nfrac   <= '0;
            r_idx     <= '0;
            r_fcnt    <= '0;
            r_cyc     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_nfrac   <= n_nfrac;
            r_idx     <= n_idx;
            r_fcnt    <= n_fcnt;
            r_cyc     <= n_cyc;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_frac   <= n_frac;
        r_m_char <= n_m_char;
        r_m_last <= n_m_last;
    end

    // Next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_nfrac   = r_nfrac;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_cyc     = r_cyc;
        n_idx     = r_idx;
        n_frac    = r_frac;
        n_fcnt    = r_fcnt;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_char  = r_m_char;
        n_m_last  = r_m_last;

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_base  = radix_sat;
                    n_nfrac = frac_sat;
                    n_dvd   = DW'(i_s_tdata[FRAC_BITS +: INT_BITS]);
                    n_frac  = i_s_tdata[FRAC_BITS-1:0];
                    n_rem   = '0;
                    n_cyc   = '0;
                    n_idx   = '0;
                    n_fcnt  = '0;
                    n_state = ST_DIV;
                end
            end
            // one chunk of the division per cycle; the digit is stored on the last chunk
            ST_DIV: begin
                n_dvd = dvd_sh[DW-1:0];
                if (r_cyc == CYC_LAST) begin
                    n_rem = '0;
                    n_cyc = '0;
                    if (dvd_sh[DW-1:0] == '0 || r_idx == IDX_LAST) begin
                        n_state = ST_INT_RD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_rem = rem_out;
                    n_cyc = r_cyc + 1'b1;
                end
            end
            ST_INT_RD: begin
                n_state = ST_INT_PUT;
            end
            // integer digits, most significant first
            ST_INT_PUT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_char  = digit_char(mem_rd_data);
                    n_m_last  = (r_idx == '0) && (r_frac == '0);
                    if (r_idx != '0) begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_INT_RD;
                    end else if (r_frac != '0) begin
                        n_state = ST_DOT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DOT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_char  = CH_DOT;
                    n_m_last  = (r_nfrac == '0);
                    n_state   = (r_nfrac == '0) ? ST_IDLE : ST_FRAC;
                end
            end
            // fraction digits, one multiply each
            ST_FRAC: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_char  = digit_char(fdigit);
                    n_frac    = frac_out;
                    n_fcnt    = r_fcnt + 1'b1;
                    n_m_last  = (n_fcnt == r_nfrac);
                    if (n_fcnt == r_nfrac) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencer
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_DIV))
        else $error("accepted item did not start division");

    a_base_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base >= RADIX_MIN) && (r_base <= RADIX_MAX))
        else $error("working radix out of range");

    a_fcnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_nfrac)
        else $error("fraction digit count overran");

    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_LAST)
        else $error("digit index beyond store");

    a_no_write_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INT_PUT || r_state == ST_INT_RD) |-> !mem_wr)
        else $error("digit store written during emission");

endmodule

>>> tb/sv/tb_fixed_point_to_radix_ascii.sv
// Self-checking testbench for the fixed-point to radix ASCII converter.
module tb_fixed_point_to_radix_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    import fpra_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned IDLE_PCT     = 38;
    localparam int unsigned RAND_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS  = 31;
    localparam int unsigned QUIET_PHASE  = 4;
    localparam int unsigned DRAIN_PHASE  = 6;

    // Indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_item;

    typedef enum logic {
        ROW_CFG,
        ROW_VALUE
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [62:0]            value;
        string                  text;   // empty: expected text comes from the predictor
    } t_dir_row;

    localparam int DIR_ROWS = 24;

    // Directed stimulus; hand-typed text only where it is obvious
    t_dir_row dir_table [DIR_ROWS] = '{
        '{ROW_VALUE, REG_RADIX,       6'd0,  63'd0,                           "0"},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'h7FFF_FFFF, 32'h0},          "2147483647"},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd0, 32'h1},                  "0."},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd5, 32'h8000_0000},          "5."},
        '{ROW_CFG,   REG_FRAC_DIGITS, 6'd4,  63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd5, 32'h8000_0000},          "5.5000"},
        '{ROW_CFG,   REG_RADIX,       6'd0,  63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd5, 32'h0},                  "101"},
        '{ROW_VALUE, REG_RADIX,       6'd0,  63'h7FFF_FFFF_FFFF_FFFF,         ""},
        '{ROW_CFG,   REG_RADIX,       6'd1,  63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd6, 32'h4000_0000},          "110.0100"},
        '{ROW_CFG,   REG_RADIX,       6'd31, 63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  63'h7FFF_FFFF_FFFF_FFFF,         "7FFFFFFF.FFFF"},
        '{ROW_CFG,   REG_FRAC_DIGITS, 6'd63, 63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd0, 32'hFFFF_FFFF},          ""},
        '{ROW_CFG,   REG_RADIX,       6'd2,  63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  63'h7FFF_FFFF_FFFF_FFFF,         ""},
        '{ROW_CFG,   REG_UNUSED_2,    6'd63, 63'd0,                           ""},
        '{ROW_CFG,   REG_UNUSED_3,    6'd0,  63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd10, 32'h0},                 "1010"},
        '{ROW_CFG,   REG_RADIX,       6'd16, 63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'hA_BCDE, 32'h0},             "ABCDE"},
        '{ROW_CFG,   REG_RADIX,       6'd10, 63'd0,                           ""},
        '{ROW_VALUE, REG_RADIX,       6'd0,  {31'd1, 32'h1},                  ""}
    };

    // DUT signals
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [S_DATA_W-1:0]    i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    o_m_tdata;
    logic                   o_m_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Shadow registers and expected characters
    logic [RADIX_W-1:0]     cfg_radix = RADIX_RESET;
    logic [FDIG_W-1:0]      cfg_frac  = '0;
    t_text_item             text_q [$];

    int unsigned err_count  = 0;
    int unsigned n_values   = 0;
    int unsigned n_chars    = 0;
    int unsigned n_writes   = 0;
    int unsigned cycles     = 0;
    bit          no_idle    = 1'b0;

    fixed_point_to_radix_ascii DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d characters pending",
                     $time, cycles, text_q.size());
            $display("[fixed_point_to_radix_ascii] ERROR");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
        return (d < DEC_LIMIT) ? CH_ZERO + CHAR_W'(d) : CH_A + CHAR_W'(d - DEC_LIMIT);
    endfunction

    // Expected text of one value under the current shadow registers
    task automatic predict_text(input logic [62:0] v);
        logic [RADIX_W-1:0] base;
        logic [FDIG_W-1:0]  nfrac;
        logic [30:0]        ipart;
        logic [31:0]        fpart;
        logic [36:0]        prod;
        logic [DIGIT_W-1:0] digs [31];
        int                 n;
        int                 i;
        t_text_item         txt [$];
        t_text_item         it;
        base = cfg_radix;
        if (base < RADIX_MIN) base = RADIX_MIN;
        if (base > RADIX_MAX) base = RADIX_MAX;
        nfrac = (cfg_frac > FDIG_W'(MAX_FRAC_DIG_DEF)) ? FDIG_W'(MAX_FRAC_DIG_DEF) : cfg_frac;
        ipart = v[62:32];
        fpart = v[31:0];
        n = 0;
        // integer digits, least significant first
        do begin
            digs[n] = DIGIT_W'(ipart % 31'(base));
            n++;
            ipart = ipart / 31'(base);
        end while (ipart != 0 && n < 31);
        it.last = 1'b0;
        for (i = n - 1; i >= 0; i--) begin
            it.ch = char_of_digit(digs[i]);
            txt.push_back(it);
        end
        // fraction digits by repeated multiply
        if (fpart != 0) begin
            it.ch = CH_DOT;
            txt.push_back(it);
            for (i = 0; i < int'(nfrac); i++) begin
                prod  = 37'(fpart) * 37'(base);
                it.ch = char_of_digit(prod[35:32]);
                fpart = prod[31:0];
                txt.push_back(it);
            end
        end
        txt[txt.size() - 1].last = 1'b1;
        foreach (txt[k]) text_q.push_back(txt[k]);
    endtask

    task automatic push_typed(input string s);
        t_text_item it;
        int         i;
        for (i = 0; i < s.len(); i++) begin
            it.ch   = CHAR_W'(s[i]);
            it.last = (i == s.len() - 1);
            text_q.push_back(it);
        end
    endtask

    // Present one value; valid stays high after acceptance until the next call
    task automatic send_value(input logic [62:0] v, input string typed);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, v};
        do @(posedge i_clk); while (!o_s_tready);
        n_values++;
        if (typed.len() == 0) predict_text(v);
        else push_typed(typed);
    endtask

    // Stop sending and wait until every character is out and the block is idle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (text_q.size() != 0 || !o_s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_writes++;
        if (idx == REG_RADIX) cfg_radix = d[RADIX_W-1:0];
        else if (idx == REG_FRAC_DIGITS) cfg_frac = d;
        @(posedge i_clk);
    endtask

    // Mix of value shapes; the full-random case reaches every bit
    function automatic logic [62:0] random_value();
        logic [30:0] ip;
        logic [31:0] fp;
        ip = 31'($urandom);
        fp = $urandom;
        case ($urandom_range(0, 5))
            0: ;
            1: ip = 31'($urandom_range(0, 255));
            2: fp = '0;
            3: ip = '0;
            4: fp = fp & 32'hFFF0_0000;
            default: begin
                ip = 31'($urandom_range(0, 40));
                fp = ($urandom_range(0, 1) != 0) ? 32'h0 : 32'($urandom_range(1, 15)) << 28;
            end
        endcase
        return {ip, fp};
    endfunction

    // Receiver: random backpressure and character check
    always @(posedge i_clk) begin : rx_side
        t_text_item want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
            if (o_m_tvalid && i_m_tready) begin
                n_chars++;
                if (text_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected character, expected none, got tdata %h last %b",
                             $time, o_m_tdata, o_m_tlast);
                end else begin
                    want = text_q.pop_front();
                    if (o_m_tdata !== {1'b0, want.ch} || o_m_tlast !== want.last) begin
                        err_count++;
                        $display("%0t: mismatch, expected tdata %h last %b, got tdata %h last %b",
                                 $time, {1'b0, want.ch}, want.last, o_m_tdata, o_m_tlast);
                    end
                end
            end
        end
    end

    // Main sequence
    initial begin : stim
        int unsigned ph;
        int unsigned k;
        logic [CFG_DATA_W-1:0] rdat;
        logic [CFG_DATA_W-1:0] fdat;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_table[r].idx, dir_table[r].data);
            end else begin
                send_value(dir_table[r].value, dir_table[r].text);
            end
        end

        // random phases, each with its own register setting
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            no_idle = (ph == QUIET_PHASE);
            case (ph)
                0: begin rdat = 6'd2;  fdat = 6'd32; end
                1: begin rdat = 6'd16; fdat = 6'd0;  end
                2: begin rdat = 6'd63; fdat = 6'd63; end
                default: begin
                    rdat = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(2, 16))
                                                        : 6'($urandom_range(0, 63));
                    k = $urandom_range(0, 99);
                    fdat = (k < 60) ? 6'($urandom_range(0, 8)) :
                           (k < 85) ? 6'($urandom_range(9, 32)) : 6'($urandom_range(33, 63));
                end
            endcase
            write_reg(REG_RADIX, rdat);
            write_reg(REG_FRAC_DIGITS, fdat);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                          6'($urandom));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold the sender until the output has fully drained
                if (ph == DRAIN_PHASE && k == PHASE_ITEMS / 2) wait_idle();
                send_value(random_value(), "");
            end
        end
        wait_idle();
        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (text_q.size() != 0) begin
            err_count++;
            $display("%0t: %0d expected characters never arrived", $time, text_q.size());
        end
        $display("Converted %0d values into %0d characters over %0d register writes,",
                 n_values, n_chars, n_writes);
        $display("bases 2..16 with saturation, 0..32 fraction digits, %0d mismatches.",
                 err_count);
        if (err_count == 0) begin
            $display("[fixed_point_to_radix_ascii] OK");
        end else begin
            $display("[fixed_point_to_radix_ascii] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
src/fpra_pkg.sv
src/fpra_arith.sv
src/fpra_digit_mem.sv
src/fixed_point_to_radix_ascii.sv
tb/sv/tb_fixed_point_to_radix_ascii.sv
